// ===== src/isl_pkg.sv =====
// Shared types and constants for the Ising lattice update unit.
`default_nettype none

package isl_pkg;

    localparam int SIDE_DEF   = 64;
    localparam int COORD_W    = 6;
    localparam int OP_W       = 2;
    localparam int DRAW_W     = 16;
    localparam int THR_W      = 17;
    localparam int J_W        = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 17;
    localparam int ENERGY_W   = 23;
    localparam int MAG_OUT_W  = 14;
    localparam int BDELTA_W   = 7;

    localparam logic [J_W-1:0]   J_RST      = 8'sd1;
    localparam logic [THR_W-1:0] WEAK_RST   = 17'd8869;
    localparam logic [THR_W-1:0] STRONG_RST = 17'd1200;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_FLIP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG   = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EXEC
    } isl_state_t;

    // sequencer strobes toward the datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic fetch;
        logic exec_go;
        logic clr_we;
    } isl_ctl_t;

    // per-transaction decision from the update logic
    typedef struct packed {
        logic                       spin_now;
        logic                       flipped;
        logic                       change;
        logic                       spin_was;
        logic signed [BDELTA_W-1:0] bond_delta;
    } isl_upd_t;

endpackage

`default_nettype wire

// ===== src/isl_ram.sv =====
// Generic synchronous RAM, one write port and two registered read ports.
`default_nettype none

module isl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic      [WIDTH-1:0]                        q_a,
    input  wire logic                                    re_b,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic      [WIDTH-1:0]                        q_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            q_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            q_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== src/isl_ctrl.sv =====
// Sequencer: lattice clearing pass after reset, then fetch / execute per transaction.
`default_nettype none

module isl_ctrl #(
    parameter int SIDE = isl_pkg::SIDE_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    input  wire logic                                    out_free,
    output isl_pkg::isl_ctl_t                            ctl,
    output logic [((SIDE > 1) ? $clog2(SIDE) : 1)-1:0]   clr_addr
);

    import isl_pkg::*;

    localparam int IDX_W = (SIDE > 1) ? $clog2(SIDE) : 1;

    isl_state_t       state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_last;

    assign clr_last = (clr_cnt_reg == IDX_W'(SIDE - 1));
    assign clr_addr = clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = in_valid ? ST_FETCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_we = 1'b1;
            end
            ST_IDLE:
            begin
                ctl.in_ready = 1'b1;
            end
            ST_FETCH:
            begin
                ctl.fetch = 1'b1;
            end
            ST_EXEC:
            begin
                ctl.exec_go  = out_free;
                ctl.in_ready = out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
        ctl.accept = ctl.in_ready & in_valid;
    end

endmodule

`default_nettype wire

// ===== src/isl_update.sv =====
// Metropolis decision and row rewrite for one site, given its row and vertical neighbours.
`default_nettype none

module isl_update #(
    parameter int SIDE = isl_pkg::SIDE_DEF
) (
    input  wire logic [SIDE-1:0]                          center_row,
    input  wire logic                                     up_bit,
    input  wire logic                                     dn_bit,
    input  wire logic [((SIDE > 1) ? $clog2(SIDE) : 1)-1:0] col,
    input  wire logic                                     in_range,
    input  wire logic [isl_pkg::OP_W-1:0]                 op,
    input  wire logic                                     wval,
    input  wire logic [isl_pkg::DRAW_W-1:0]               draw,
    input  wire logic signed [isl_pkg::J_W-1:0]           coupling_j,
    input  wire logic [isl_pkg::THR_W-1:0]                accept_weak,
    input  wire logic [isl_pkg::THR_W-1:0]                accept_strong,
    output isl_pkg::isl_upd_t                             upd,
    output logic [SIDE-1:0]                               new_row
);

    import isl_pkg::*;

    localparam int IDX_W = (SIDE > 1) ? $clog2(SIDE) : 1;

    logic [IDX_W-1:0]          col_l, col_r;
    logic                      s, lf_bit, rt_bit;
    logic [2:0]                k;
    logic                      n_pos, n_zero, mag2, j_pos, j_zero, p_pos;
    logic [THR_W-1:0]          thr;
    logic                      take, change, flip;
    logic signed [BDELTA_W-1:0] n4;

    assign col_l = (col == '0) ? IDX_W'(SIDE - 1) : col - 1'b1;
    assign col_r = (col == IDX_W'(SIDE - 1)) ? '0 : col + 1'b1;

    assign s      = center_row[col];
    assign lf_bit = center_row[col_l];
    assign rt_bit = center_row[col_r];

    // count of +1 neighbours; neighbour sum is 2k - 4
    assign k = 3'(up_bit) + 3'(dn_bit) + 3'(lf_bit) + 3'(rt_bit);

    assign n_pos  = (k >= 3'd3);
    assign n_zero = (k == 3'd2);
    assign mag2   = (k == 3'd1) || (k == 3'd3);
    assign j_zero = (coupling_j == '0);
    assign j_pos  = !coupling_j[J_W-1] && !j_zero;

    // sign of J * s * nsum
    assign p_pos = !j_zero && !n_zero && (j_pos ^ s ^ n_pos);

    assign thr  = mag2 ? accept_weak : accept_strong;
    assign take = !p_pos || ({1'b0, draw} < thr);

    always_comb
    begin
        case (op)
            OP_WRITE:
            begin
                change = (wval != s);
                flip   = 1'b0;
            end
            OP_FLIP:
            begin
                change = take;
                flip   = take;
            end
            default:
            begin
                change = 1'b0;
                flip   = 1'b0;
            end
        endcase
    end

    // 4 * nsum = 8k - 16
    assign n4 = $signed({1'b0, k, 3'b000}) - 7'sd16;

    always_comb
    begin
        new_row      = center_row;
        new_row[col] = !s;
    end

    always_comb
    begin
        upd.change     = in_range && change;
        upd.flipped    = in_range && flip;
        upd.spin_now   = in_range && (change ? !s : s);
        upd.spin_was   = s;
        upd.bond_delta = s ? -n4 : n4;
    end

endmodule

`default_nettype wire

// ===== src/ising_metropolis_lattice_unit.sv =====
// Top level: 2D periodic Ising lattice with Metropolis flip, write and read transactions.
//
// Input channel (in_valid/in_ready) carries opcode, row, col, spin_value, random_draw.
// Output channel (out_valid/out_ready) returns one result per transaction: spin_now,
// flipped, energy_total (-J times bond sum) and magnetization.
// The lattice sits in a RAM of SIDE rows of SIDE bits with two read ports. A transaction
// reads the rows above and below at acceptance, its own row in the next cycle, and in
// the execute state decides, writes the row back and loads the result register.
// A transaction needs three row reads over two RAM read ports; the next transaction is
// taken in the write-back cycle, with a bypass for a row written in that same cycle.
// The result register frees the input side: a new transaction is taken while a result
// waits. If the receiver stalls with a result pending, the next result is held in the
// write-back stage and in_ready stays low until the register drains.
// Reset: registers return to defaults and a clearing pass writes all rows to +1 with
// in_ready low. cfg_we writes take effect at once.
`default_nettype none

module ising_metropolis_lattice_unit #(
    parameter int SIDE = isl_pkg::SIDE_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [isl_pkg::OP_W-1:0]           opcode,
    input  wire logic [isl_pkg::COORD_W-1:0]        row,
    input  wire logic [isl_pkg::COORD_W-1:0]        col,
    input  wire logic                               spin_value,
    input  wire logic [isl_pkg::DRAW_W-1:0]         random_draw,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    spin_now,
    output logic                                    flipped,
    output logic signed [isl_pkg::ENERGY_W-1:0]    energy_total,
    output logic signed [isl_pkg::MAG_OUT_W-1:0]   magnetization,
    input  wire logic                               cfg_we,
    input  wire logic [isl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [isl_pkg::CFG_W-1:0]          cfg_data
);

    import isl_pkg::*;

    localparam int IDX_W   = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int CMP_W   = COORD_W + 3;
    localparam int SITES   = SIDE * SIDE;
    localparam int BOND_W  = $clog2(4 * SITES + 1) + 1;
    localparam int MAG_W   = $clog2(SITES + 1) + 1;
    localparam int PROD_W  = J_W + BOND_W;
    localparam int E_W     = (PROD_W > ENERGY_W) ? PROD_W : ENERGY_W;
    localparam int MX_W    = (MAG_W > MAG_OUT_W) ? MAG_W : MAG_OUT_W;

    isl_ctl_t          ctl;
    isl_upd_t          upd;
    logic              out_free;
    logic [IDX_W-1:0]  clr_addr;

    // configuration
    logic signed [J_W-1:0] j_reg;
    logic [THR_W-1:0]      weak_reg, strong_reg;

    // current transaction
    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  row_reg, col_reg;
    logic              wval_reg, inr_reg;
    logic [DRAW_W-1:0] draw_reg;
    logic              up_bit_reg, dn_bit_reg;

    // address decode of the incoming site
    logic [CMP_W-1:0]  row_x, col_x;
    logic [IDX_W-1:0]  row_i, col_i, row_up, row_dn;
    logic              in_range;

    // RAM ports
    logic              ram_we, re_a, re_b;
    logic [IDX_W-1:0]  waddr, raddr_a, raddr_b;
    logic [SIDE-1:0]   wdata, q_a, q_b, new_row;
    logic              fwd_a_reg, fwd_b_reg;
    logic [SIDE-1:0]   fwd_row_reg;
    logic [SIDE-1:0]   nb_row_a, nb_row_b;

    // totals
    logic signed [BOND_W-1:0] bond_reg, bond_next;
    logic signed [MAG_W-1:0]  spin_tot_reg, spin_tot_next;
    logic signed [E_W-1:0]    prod;
    logic signed [E_W-1:0]    energy_x;
    logic signed [MX_W-1:0]   mag_x;

    // output register
    logic                        out_valid_reg;
    logic                        spin_now_reg, flipped_reg;
    logic signed [ENERGY_W-1:0]  energy_reg;
    logic signed [MAG_OUT_W-1:0] mag_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = ctl.in_ready;

    isl_ctrl #(
        .SIDE (SIDE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .ctl      (ctl),
        .clr_addr (clr_addr)
    );

    assign row_x    = CMP_W'(row);
    assign col_x    = CMP_W'(col);
    assign row_i    = row_x[IDX_W-1:0];
    assign col_i    = col_x[IDX_W-1:0];
    assign in_range = (row_x < CMP_W'(SIDE)) && (col_x < CMP_W'(SIDE));
    assign row_up   = (row_i == IDX_W'(SIDE - 1)) ? '0 : row_i + 1'b1;
    assign row_dn   = (row_i == '0) ? IDX_W'(SIDE - 1) : row_i - 1'b1;

    // neighbour rows at acceptance, own row during fetch
    assign re_a    = ctl.accept || ctl.fetch;
    assign re_b    = ctl.accept;
    assign raddr_a = ctl.accept ? row_up : row_reg;
    assign raddr_b = row_dn;

    assign ram_we = ctl.clr_we || (ctl.exec_go && upd.change);
    assign waddr  = ctl.clr_we ? clr_addr : row_reg;
    assign wdata  = ctl.clr_we ? {SIDE{1'b1}} : new_row;

    isl_ram #(
        .WIDTH (SIDE),
        .DEPTH (SIDE)
    ) u_lattice (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .q_a     (q_a),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .q_b     (q_b)
    );

    // bypass a row written on the same edge it was read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else
        begin
            fwd_a_reg <= ram_we && re_a && (waddr == raddr_a);
            fwd_b_reg <= ram_we && re_b && (waddr == raddr_b);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_row_reg <= wdata;
    end

    assign nb_row_a = fwd_a_reg ? fwd_row_reg : q_a;
    assign nb_row_b = fwd_b_reg ? fwd_row_reg : q_b;

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            op_reg   <= opcode;
            row_reg  <= row_i;
            col_reg  <= col_i;
            wval_reg <= spin_value;
            draw_reg <= random_draw;
            inr_reg  <= in_range;
        end
        if (ctl.fetch)
        begin
            up_bit_reg <= nb_row_a[col_reg];
            dn_bit_reg <= nb_row_b[col_reg];
        end
    end

    isl_update #(
        .SIDE (SIDE)
    ) u_update (
        .center_row    (q_a),
        .up_bit        (up_bit_reg),
        .dn_bit        (dn_bit_reg),
        .col           (col_reg),
        .in_range      (inr_reg),
        .op            (op_reg),
        .wval          (wval_reg),
        .draw          (draw_reg),
        .coupling_j    (j_reg),
        .accept_weak   (weak_reg),
        .accept_strong (strong_reg),
        .upd           (upd),
        .new_row       (new_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg      <= J_RST;
            weak_reg   <= WEAK_RST;
            strong_reg <= STRONG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COUPLING: j_reg      <= cfg_data[J_W-1:0];
                CFG_WEAK:     weak_reg   <= cfg_data[THR_W-1:0];
                CFG_STRONG:   strong_reg <= cfg_data[THR_W-1:0];
                default:      j_reg      <= j_reg;
            endcase
        end
    end

    // flipping spin s changes bond sum by -4*s*nsum and spin total by -2*s
    always_comb
    begin
        bond_next     = bond_reg;
        spin_tot_next = spin_tot_reg;
        if (upd.change)
        begin
            bond_next     = bond_reg + BOND_W'(upd.bond_delta);
            spin_tot_next = upd.spin_was ? spin_tot_reg - MAG_W'(2)
                                         : spin_tot_reg + MAG_W'(2);
        end
    end

    assign prod     = E_W'(j_reg) * E_W'(bond_next);
    assign energy_x = -prod;
    assign mag_x    = MX_W'(spin_tot_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bond_reg     <= BOND_W'(4 * SITES);
            spin_tot_reg <= MAG_W'(SITES);
        end
        else if (ctl.exec_go)
        begin
            bond_reg     <= bond_next;
            spin_tot_reg <= spin_tot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec_go)
        begin
            spin_now_reg <= upd.spin_now;
            flipped_reg  <= upd.flipped;
            energy_reg   <= energy_x[ENERGY_W-1:0];
            mag_reg      <= mag_x[MAG_OUT_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign spin_now      = spin_now_reg;
    assign flipped       = flipped_reg;
    assign energy_total  = energy_reg;
    assign magnetization = mag_reg;

endmodule

`default_nettype wire

// ===== dv/ising_metropolis_lattice_unit_tb.sv =====
// Self-checking testbench for the Ising lattice Metropolis update unit.
`timescale 1ns / 100ps

module ising_metropolis_lattice_unit_tb;

    import isl_pkg::*;

    localparam int SIDE         = SIDE_DEF;
    localparam int SITES        = SIDE * SIDE;
    localparam int NDIR         = 20;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 190;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic                        spin;
        logic                        flip;
        logic signed [ENERGY_W-1:0]  energy;
        logic signed [MAG_OUT_W-1:0] mag;
    } lattice_result_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic               sv;
        logic [DRAW_W-1:0]  draw;
        logic               typed;
        lattice_result_t    res;
    } stim_row_t;

    localparam logic signed [ENERGY_W-1:0]  E_RESET = -23'sd16384;
    localparam logic signed [ENERGY_W-1:0]  E_ONE   = -23'sd16368;
    localparam logic signed [MAG_OUT_W-1:0] M_RESET = 14'sd4096;
    localparam logic signed [MAG_OUT_W-1:0] M_ONE   = 14'sd4094;
    localparam lattice_result_t NO_RES = '0;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [OP_W-1:0]      opcode = OP_READ;
    logic [COORD_W-1:0]   row = '0;
    logic [COORD_W-1:0]   col = '0;
    logic                 spin_value = 1'b0;
    logic [DRAW_W-1:0]    random_draw = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    logic                 spin_now;
    logic                 flipped;
    logic signed [ENERGY_W-1:0]  energy_total;
    logic signed [MAG_OUT_W-1:0] magnetization;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // lattice mirror and running totals
    bit     spin_grid [0:SITES-1];
    longint bond_total;
    longint magnet_total;
    int     j_coupling;
    int     thr_weak;
    int     thr_strong;

    lattice_result_t expected_results [$];
    int              fail_count = 0;
    int              hold_count = 0;
    stim_row_t       dir_rows [0:NDIR-1];

    ising_metropolis_lattice_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .row           (row),
        .col           (col),
        .spin_value    (spin_value),
        .random_draw   (random_draw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .spin_now      (spin_now),
        .flipped       (flipped),
        .energy_total  (energy_total),
        .magnetization (magnetization),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int spin_of(int r, int c);
        return spin_grid[r * SIDE + c] ? 1 : -1;
    endfunction

    task automatic predict_transaction(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r,
            input logic [COORD_W-1:0] c, input logic sv, input logic [DRAW_W-1:0] draw,
            output lattice_result_t res);
        int     ri;
        int     ci;
        int     idx;
        int     s;
        int     nsum;
        int     wv;
        int     p;
        int     nmag;
        int     thr;
        bit     take;
        longint en;
        ri = int'(r);
        ci = int'(c);
        res = '0;
        if (ri < SIDE && ci < SIDE)
        begin
            idx = ri * SIDE + ci;
            s = spin_of(ri, ci);
            nsum = spin_of((ri + 1) % SIDE, ci) + spin_of(ri, (ci + 1) % SIDE)
                 + spin_of((ri + SIDE - 1) % SIDE, ci) + spin_of(ri, (ci + SIDE - 1) % SIDE);
            if (op == OP_WRITE)
            begin
                wv = sv ? 1 : -1;
                bond_total   += 2 * (wv - s) * nsum;
                magnet_total += wv - s;
                spin_grid[idx] = sv;
            end
            else if (op == OP_FLIP)
            begin
                p = j_coupling * s * nsum;
                if (p <= 0)
                    take = 1'b1;
                else
                begin
                    nmag = (nsum < 0) ? -nsum : nsum;
                    thr  = (nmag == 2) ? thr_weak : thr_strong;
                    take = int'(draw) < thr;
                end
                if (take)
                begin
                    bond_total   -= 4 * s * nsum;
                    magnet_total -= 2 * s;
                    spin_grid[idx] = ~spin_grid[idx];
                    res.flip = 1'b1;
                end
            end
            // opcode read and the spare opcode leave the lattice alone
            res.spin = spin_grid[idx];
        end
        en = -longint'(j_coupling) * bond_total;
        res.energy = en[ENERGY_W-1:0];
        res.mag    = magnet_total[MAG_OUT_W-1:0];
    endtask

    // caller sits just after a rising edge; valid is left high on return
    task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r,
            input logic [COORD_W-1:0] c, input logic sv, input logic [DRAW_W-1:0] draw,
            input logic typed, input lattice_result_t typed_res);
        lattice_result_t res;
        in_valid    <= 1'b1;
        opcode      <= op;
        row         <= r;
        col         <= c;
        spin_value  <= sv;
        random_draw <= draw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_transaction(op, r, c, sv, draw, res);
        if (typed)
            res = typed_res;
        expected_results = {expected_results, res};
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] j_word, input logic [CFG_W-1:0] w_word,
            input logic [CFG_W-1:0] s_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COUPLING;
        cfg_data  <= j_word;
        @(posedge clk);
        j_coupling = int'($signed(j_word[J_W-1:0]));
        cfg_index <= CFG_WEAK;
        cfg_data  <= w_word;
        @(posedge clk);
        thr_weak = int'(w_word);
        cfg_index <= CFG_STRONG;
        cfg_data  <= s_word;
        @(posedge clk);
        thr_strong = int'(s_word);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_result(input lattice_result_t exp);
        if (spin_now !== exp.spin)
        begin
            $error("spin_now exp %0d act %0d", exp.spin, spin_now);
            fail_count++;
        end
        if (flipped !== exp.flip)
        begin
            $error("flipped exp %0d act %0d", exp.flip, flipped);
            fail_count++;
        end
        if (energy_total !== exp.energy)
        begin
            $error("energy_total exp %0d act %0d", exp.energy, energy_total);
            fail_count++;
        end
        if (magnetization !== exp.mag)
        begin
            $error("magnetization exp %0d act %0d", exp.mag, magnetization);
            fail_count++;
        end
    endtask

    // result side: check on each transaction, then update the stall pattern
    always @(posedge clk)
    begin
        logic rdy;
        rdy = out_ready;
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
                check_result(expected_results.pop_front());
        end
        if (hold_count == 0)
        begin
            if (out_ready && $urandom_range(0, 1))
            begin
                rdy = 1'b0;
                hold_count = $urandom_range(1, 6);
            end
            else
            begin
                rdy = 1'b1;
                hold_count = $urandom_range(1, 40);
            end
        end
        else
            hold_count--;
        out_ready <= rdy;
    end

    initial
    begin
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic               sv;
        logic [DRAW_W-1:0]  draw;
        int                 pick;
        int                 tmp;
        int                 burst_left;
        int                 gap;

        foreach (spin_grid[i])
            spin_grid[i] = 1'b1;
        bond_total   = 4 * SITES;
        magnet_total = SITES;
        j_coupling   = int'($signed(J_RST));
        thr_weak     = int'(WEAK_RST);
        thr_strong   = int'(STRONG_RST);

        dir_rows = '{
            '{OP_READ,  6'd0,  6'd0,  1'b0, 16'h0000, 1'b1, '{1'b1, 1'b0, E_RESET, M_RESET}},
            '{OP_SPARE, 6'd63, 6'd63, 1'b1, 16'hFFFF, 1'b1, '{1'b1, 1'b0, E_RESET, M_RESET}},
            '{OP_FLIP,  6'd5,  6'd5,  1'b0, 16'hFFFF, 1'b1, '{1'b1, 1'b0, E_RESET, M_RESET}},
            '{OP_FLIP,  6'd5,  6'd5,  1'b1, 16'h0000, 1'b1, '{1'b0, 1'b1, E_ONE,   M_ONE}},
            '{OP_FLIP,  6'd5,  6'd5,  1'b0, 16'hFFFF, 1'b1, '{1'b1, 1'b1, E_RESET, M_RESET}},
            '{OP_WRITE, 6'd5,  6'd5,  1'b1, 16'h0000, 1'b1, '{1'b1, 1'b0, E_RESET, M_RESET}},
            '{OP_WRITE, 6'd0,  6'd0,  1'b0, 16'h5555, 1'b0, NO_RES},
            '{OP_WRITE, 6'd0,  6'd2,  1'b0, 16'hAAAA, 1'b0, NO_RES},
            // neighbours cancel: no energy change, flips regardless of draw
            '{OP_FLIP,  6'd0,  6'd1,  1'b0, 16'hFFFF, 1'b0, NO_RES},
            '{OP_FLIP,  6'd1,  6'd0,  1'b0, 16'd8868, 1'b0, NO_RES},
            '{OP_WRITE, 6'd1,  6'd0,  1'b1, 16'h0000, 1'b0, NO_RES},
            '{OP_FLIP,  6'd1,  6'd0,  1'b0, 16'd8869, 1'b0, NO_RES},
            '{OP_FLIP,  6'd10, 6'd10, 1'b1, 16'd1199, 1'b0, NO_RES},
            '{OP_FLIP,  6'd20, 6'd20, 1'b1, 16'd1200, 1'b0, NO_RES},
            '{OP_WRITE, 6'd63, 6'd63, 1'b0, 16'h0F0F, 1'b0, NO_RES},
            '{OP_WRITE, 6'd63, 6'd0,  1'b0, 16'hF0F0, 1'b0, NO_RES},
            '{OP_FLIP,  6'd0,  6'd63, 1'b0, 16'h8000, 1'b0, NO_RES},
            '{OP_READ,  6'd63, 6'd0,  1'b1, 16'h7FFF, 1'b0, NO_RES},
            '{OP_WRITE, 6'd32, 6'd31, 1'b0, 16'h0001, 1'b0, NO_RES},
            '{OP_READ,  6'd0,  6'd1,  1'b0, 16'hFFFE, 1'b0, NO_RES}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        for (int i = 0; i < NDIR; i++)
            send_item(dir_rows[i].op, dir_rows[i].r, dir_rows[i].c, dir_rows[i].sv,
                      dir_rows[i].draw, dir_rows[i].typed, dir_rows[i].res);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: apply_settings({9'($urandom), 8'sd1}, 17'd8869, 17'd1200);
                1: apply_settings({9'd0, 8'sd127}, 17'd65536, 17'd0);
                2: apply_settings({9'h1FF, -8'sd128}, 17'd0, 17'd65536);
                3: apply_settings(17'd0, 17'($urandom_range(0, 65536)),
                                  17'($urandom_range(0, 65536)));
                4: apply_settings({9'd0, -8'sd1}, 17'($urandom_range(0, 65536)),
                                  17'($urandom_range(0, 65536)));
                default: apply_settings(17'($urandom), 17'($urandom_range(0, 65536)),
                                        17'($urandom_range(0, 65536)));
            endcase

            burst_left = $urandom_range(1, 16);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    op = OP_FLIP;
                else if (pick < 80)
                    op = OP_WRITE;
                else if (pick < 95)
                    op = OP_READ;
                else
                    op = OP_SPARE;
                if ($urandom_range(0, 1))
                begin
                    r = 6'($urandom);
                    c = 6'($urandom);
                end
                else
                begin
                    // small window across the wrap corner so neighbours interact
                    r = 6'(($urandom_range(0, 1) ? 60 : 0) + $urandom_range(0, 3));
                    c = 6'(($urandom_range(0, 1) ? 60 : 0) + $urandom_range(0, 3));
                end
                sv = 1'($urandom);
                if ($urandom_range(0, 9) < 6)
                    draw = 16'($urandom);
                else
                begin
                    tmp = ($urandom_range(0, 1) ? thr_weak : thr_strong)
                        + int'($urandom_range(0, 4)) - 2;
                    if (tmp < 0)
                        tmp = 0;
                    if (tmp > 65535)
                        tmp = 65535;
                    draw = 16'(tmp);
                end
                send_item(op, r, c, sv, draw, 1'b0, NO_RES);

                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/isl_pkg.sv
src/isl_ram.sv
src/isl_ctrl.sv
src/isl_update.sv
src/ising_metropolis_lattice_unit.sv
dv/ising_metropolis_lattice_unit_tb.sv
